/* hdl/lphm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lphm_pkg
// shared types and constants of the linear probe hash map
// ----------------------------------------------------------------------------
package lphm_pkg;

  localparam int MAX_SLOTS_LOG_DEF = 8;
  localparam int KEY_BITS_DEF      = 32;
  localparam int VALUE_BITS_DEF    = 64;

  localparam logic [3:0] INIT_CAP_LOG_RST = 4'd3;

  localparam logic [1:0] ACT_SET  = 2'd0;
  localparam logic [1:0] ACT_LOOK = 2'd1;
  localparam logic [1:0] ACT_REM  = 2'd2;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef enum logic [1:0] {
    OP_SET,
    OP_LOOK,
    OP_REM,
    OP_NOP
  } op_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] key;
    logic [31:0] key_hash;
    logic [63:0] value;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [63:0] read_value;
    logic [1:0]  status;
    logic [8:0]  live_entries;
  } out_item_t;

  typedef struct packed {
    op_e         op;
    logic [31:0] key;
    logic [31:0] key_hash;
    logic [63:0] value;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } eng_status_t;

endpackage
`default_nettype wire

/* hdl/lphm_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lphm_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module lphm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

/* hdl/lphm_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lphm_front
// accepts items, decodes the action and queues commands for the engine
// ----------------------------------------------------------------------------
module lphm_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push,
  output logic                       full,
  input  wire lphm_pkg::in_item_t    in_item_i,
  input  wire lphm_pkg::eng_status_t eng_status_i,
  output logic                       cmd_valid_o,
  output lphm_pkg::cmd_t             cmd_o,
  input  wire logic                  cmd_take_i
);
  import lphm_pkg::*;

  cmd_t       q_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  cmd_t       dec;
  logic       acc;

  always_comb begin
    dec.key      = in_item_i.key;
    dec.key_hash = in_item_i.key_hash;
    dec.value    = in_item_i.value;
    unique case (in_item_i.action)
      ACT_SET:  dec.op = OP_SET;
      ACT_LOOK: dec.op = OP_LOOK;
      ACT_REM:  dec.op = OP_REM;
      default:  dec.op = OP_NOP;
    endcase
  end

  assign full        = (cnt_q == 2'd2) || eng_status_i.clearing;
  assign acc         = push && !full;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (acc) begin
      q_q[wp_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (acc) wp_q <= ~wp_q;
      if (cmd_take_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, acc} - {1'b0, cmd_take_i};
    end
  end

endmodule
`default_nettype wire

/* hdl/lphm_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lphm_engine
// probe sequencer, rehash walker and clearing pass over the slot memory
// ----------------------------------------------------------------------------
module lphm_engine #(
  parameter int MAX_SLOTS_LOG = lphm_pkg::MAX_SLOTS_LOG_DEF,
  parameter int KEY_BITS      = lphm_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS    = lphm_pkg::VALUE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  input  wire logic [3:0]            cfg_data_i,
  input  wire logic                  cmd_valid_i,
  input  wire lphm_pkg::cmd_t        cmd_i,
  output logic                       cmd_take_o,
  output lphm_pkg::eng_status_t      eng_status_o,
  output logic                       res_valid_o,
  output lphm_pkg::out_item_t        res_o,
  input  wire logic                  res_take_i
);
  import lphm_pkg::*;

  localparam int M  = MAX_SLOTS_LOG;
  localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int VW = VALUE_BITS;
  localparam int LW = $clog2(MAX_SLOTS_LOG + 1);
  localparam int CW = (LW > 4) ? LW : 4;
  localparam int EW = 2 + M + KW + VW;

  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_LIVE  = 2'd1;
  localparam logic [1:0] MARK_DEAD  = 2'd2;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_SGO  = 4'd3;
  localparam logic [3:0] S_PRD  = 4'd4;
  localparam logic [3:0] S_PEV  = 4'd5;
  localparam logic [3:0] S_RRD  = 4'd6;
  localparam logic [3:0] S_REV  = 4'd7;
  localparam logic [3:0] S_RPRD = 4'd8;
  localparam logic [3:0] S_RPEV = 4'd9;

  typedef struct packed {
    logic [1:0]    mark;
    logic [M-1:0]  hbits;
    logic [KW-1:0] key;
    logic [VW-1:0] val;
  } entry_t;

  function automatic logic [M:0] cap_of(logic [LW-1:0] lg);
    return {{M{1'b0}}, 1'b1} << lg;
  endfunction

  function automatic logic [M-1:0] mask_of(logic [LW-1:0] lg);
    logic [M:0] c;
    c = cap_of(lg);
    return c[M-1:0] - {{(M-1){1'b0}}, 1'b1};
  endfunction

  function automatic logic [LW-1:0] clamp_log(logic [3:0] v);
    logic [CW-1:0] w;
    w = CW'(v);
    if (w < CW'(2)) return LW'(2);
    else if (w > CW'(M)) return LW'(M);
    else return LW'(w);
  endfunction

  logic [3:0]    state_q, state_d;
  logic          bank_q, bank_d;
  logic [LW-1:0] caplog_q, caplog_d;
  logic [M:0]    live_q, live_d, dead_q, dead_d;
  op_e           op_q, op_d;
  logic [KW-1:0] key_q, key_d;
  logic [M-1:0]  hash_q, hash_d;
  logic [VW-1:0] val_q, val_d;
  logic [M-1:0]  idx_q, idx_d;
  logic [M:0]    n_q, n_d;
  logic          hf_q, hf_d;
  logic [M-1:0]  free_q, free_d;
  logic [M:0]    rbi_q, rbi_d;
  logic [M-1:0]  ridx_q, ridx_d;
  logic [M:0]    cnt_q, cnt_d;
  entry_t        ent_q, ent_d;
  logic [M:0]    clr_q, clr_d;
  logic          clr_all_q, clr_all_d;
  logic          rv_q, rv_d;
  logic          rfound_q, rfound_d;
  logic [VW-1:0] rval_q, rval_d;
  logic [1:0]    rstat_q, rstat_d;

  logic          we;
  logic [M:0]    waddr, raddr;
  entry_t        wdata, rd;
  logic [EW-1:0] rd_raw;

  logic [M-1:0]  mask, nmask;
  logic [M:0]    cap;
  logic [LW-1:0] newlog;
  logic [M+2:0]  load2;
  logic          key_eq, hf_n, last;
  logic [M-1:0]  free_n;

  assign rd     = entry_t'(rd_raw);
  assign mask   = mask_of(caplog_q);
  assign cap    = cap_of(caplog_q);
  assign newlog = (caplog_q < LW'(M)) ? caplog_q + LW'(1) : LW'(M);
  assign nmask  = mask_of(newlog);
  assign load2  = {(M+2)'(live_q) + (M+2)'(dead_q), 1'b0};
  assign key_eq = (rd.key == key_q);
  assign last   = ((n_q + (M+1)'(1)) == cap);
  assign hf_n   = hf_q || (rd.mark == MARK_DEAD);
  assign free_n = hf_q ? free_q : idx_q;

  lphm_ram #(
    .WIDTH (EW),
    .DEPTH (2 * (1 << M))
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd_raw)
  );

  always_comb begin
    state_d   = state_q;   bank_d  = bank_q;   caplog_d = caplog_q;
    live_d    = live_q;    dead_d  = dead_q;
    op_d      = op_q;      key_d   = key_q;    hash_d   = hash_q;
    val_d     = val_q;     idx_d   = idx_q;    n_d      = n_q;
    hf_d      = hf_q;      free_d  = free_q;   rbi_d    = rbi_q;
    ridx_d    = ridx_q;    cnt_d   = cnt_q;    ent_d    = ent_q;
    clr_d     = clr_q;     clr_all_d = clr_all_q;
    rv_d      = rv_q && !res_take_i;
    rfound_d  = rfound_q;  rval_d  = rval_q;   rstat_d  = rstat_q;
    cmd_take_o = 1'b0;
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;

    unique case (state_q)
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_all_q ? clr_q : {~bank_q, clr_q[M-1:0]};
        clr_d = clr_q + (M+1)'(1);
        if (clr_all_q ? (&clr_q) : (&clr_q[M-1:0])) begin
          if (clr_all_q) begin
            state_d = S_IDLE;
          end else begin
            rbi_d   = '0;
            cnt_d   = '0;
            state_d = S_RRD;
          end
        end
      end
      S_IDLE: begin
        if (cmd_valid_i && !rv_q) begin
          cmd_take_o = 1'b1;
          op_d   = cmd_i.op;
          key_d  = cmd_i.key[KW-1:0];
          hash_d = cmd_i.key_hash[M-1:0];
          val_d  = cmd_i.value[VW-1:0];
          idx_d  = cmd_i.key_hash[M-1:0] & mask;
          n_d    = '0;
          hf_d   = 1'b0;
          unique case (cmd_i.op)
            OP_SET:  state_d = S_CHK;
            OP_LOOK, OP_REM: state_d = S_PRD;
            default: begin
              rv_d     = 1'b1;
              rfound_d = 1'b0;
              rval_d   = '0;
              rstat_d  = ST_DONE;
            end
          endcase
        end
      end
      S_CHK: begin
        if (load2 > (M+3)'(cap)) begin
          clr_d     = '0;
          clr_all_d = 1'b0;
          state_d   = S_CLR;
        end else begin
          state_d = S_SGO;
        end
      end
      S_SGO: begin
        idx_d   = hash_q & mask;
        n_d     = '0;
        hf_d    = 1'b0;
        state_d = S_PRD;
      end
      S_PRD: begin
        raddr   = {bank_q, idx_q};
        state_d = S_PEV;
      end
      S_PEV: begin
        rfound_d = 1'b0;
        rval_d   = '0;
        rstat_d  = ST_DONE;
        idx_d    = (idx_q + M'(1)) & mask;
        n_d      = n_q + (M+1)'(1);
        if (op_q == OP_SET) begin
          wdata = '{mark: MARK_LIVE, hbits: hash_q, key: key_q, val: val_q};
          priority if (rd.mark == MARK_EMPTY) begin
            we     = 1'b1;
            waddr  = {bank_q, free_n};
            live_d = live_q + (M+1)'(1);
            if (hf_q) dead_d = dead_q - (M+1)'(1);
            rv_d    = 1'b1;
            state_d = S_IDLE;
          end else if (rd.mark == MARK_LIVE && key_eq) begin
            we       = 1'b1;
            waddr    = {bank_q, idx_q};
            wdata    = '{mark: MARK_LIVE, hbits: rd.hbits, key: rd.key, val: val_q};
            rfound_d = 1'b1;
            rv_d     = 1'b1;
            state_d  = S_IDLE;
          end else begin
            if (rd.mark == MARK_DEAD && !hf_q) begin
              hf_d   = 1'b1;
              free_d = idx_q;
            end
            if (last) begin
              rv_d    = 1'b1;
              state_d = S_IDLE;
              if (hf_n) begin
                we     = 1'b1;
                waddr  = {bank_q, free_n};
                live_d = live_q + (M+1)'(1);
                dead_d = dead_q - (M+1)'(1);
              end else begin
                rstat_d = ST_FULL;
              end
            end else begin
              state_d = S_PRD;
            end
          end
        end else begin
          // lookup and remove stop at the first empty slot
          priority if (rd.mark == MARK_EMPTY) begin
            rstat_d = ST_ABSENT;
            rv_d    = 1'b1;
            state_d = S_IDLE;
          end else if (rd.mark == MARK_LIVE && key_eq) begin
            rfound_d = 1'b1;
            rv_d     = 1'b1;
            state_d  = S_IDLE;
            if (op_q == OP_LOOK) begin
              rval_d = rd.val;
            end else begin
              we     = 1'b1;
              waddr  = {bank_q, idx_q};
              wdata  = '{mark: MARK_DEAD, hbits: rd.hbits, key: rd.key, val: rd.val};
              live_d = live_q - (M+1)'(1);
              dead_d = dead_q + (M+1)'(1);
            end
          end else if (last) begin
            rstat_d = ST_ABSENT;
            rv_d    = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_PRD;
          end
        end
      end
      S_RRD: begin
        if (rbi_q == cap) begin
          bank_d   = ~bank_q;
          caplog_d = newlog;
          live_d   = cnt_q;
          dead_d   = '0;
          state_d  = S_SGO;
        end else begin
          raddr   = {bank_q, rbi_q[M-1:0]};
          state_d = S_REV;
        end
      end
      S_REV: begin
        if (rd.mark == MARK_LIVE) begin
          ent_d   = rd;
          ridx_d  = rd.hbits & nmask;
          state_d = S_RPRD;
        end else begin
          rbi_d   = rbi_q + (M+1)'(1);
          state_d = S_RRD;
        end
      end
      S_RPRD: begin
        raddr   = {~bank_q, ridx_q};
        state_d = S_RPEV;
      end
      S_RPEV: begin
        if (rd.mark == MARK_EMPTY) begin
          we      = 1'b1;
          waddr   = {~bank_q, ridx_q};
          wdata   = ent_q;
          cnt_d   = cnt_q + (M+1)'(1);
          rbi_d   = rbi_q + (M+1)'(1);
          state_d = S_RRD;
        end else begin
          ridx_d  = (ridx_q + M'(1)) & nmask;
          state_d = S_RPRD;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // a register write restarts the table like a reset
    if (cfg_valid_i) begin
      bank_d    = 1'b0;
      caplog_d  = clamp_log(cfg_data_i);
      live_d    = '0;
      dead_d    = '0;
      clr_d     = '0;
      clr_all_d = 1'b1;
      state_d   = S_CLR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      bank_q    <= 1'b0;
      caplog_q  <= clamp_log(INIT_CAP_LOG_RST);
      live_q    <= '0;
      dead_q    <= '0;
      clr_q     <= '0;
      clr_all_q <= 1'b1;
      rv_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      bank_q    <= bank_d;
      caplog_q  <= caplog_d;
      live_q    <= live_d;
      dead_q    <= dead_d;
      clr_q     <= clr_d;
      clr_all_q <= clr_all_d;
      rv_q      <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    hash_q   <= hash_d;
    val_q    <= val_d;
    idx_q    <= idx_d;
    n_q      <= n_d;
    hf_q     <= hf_d;
    free_q   <= free_d;
    rbi_q    <= rbi_d;
    ridx_q   <= ridx_d;
    cnt_q    <= cnt_d;
    ent_q    <= ent_d;
    rfound_q <= rfound_d;
    rval_q   <= rval_d;
    rstat_q  <= rstat_d;
  end

  assign eng_status_o.clearing = (state_q == S_CLR) && clr_all_q;
  assign res_valid_o           = rv_q;
  assign res_o.found           = rfound_q;
  assign res_o.read_value      = 64'(rval_q);
  assign res_o.status          = rstat_q;
  assign res_o.live_entries    = 9'(live_q);

endmodule
`default_nettype wire

/* hdl/linear_probe_hash_map_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_probe_hash_map_core
// open addressed key/value table with linear probing and tombstones
// ----------------------------------------------------------------------------
// a lookup or remove reads and checks one slot per probe; a set first checks the load
// the engine takes the next command only when idle and the last result has been popped
// a rehash before a set clears the other bank, walks every old slot and reinserts
// each live entry into the new bank
// after reset and after every register write a clearing pass over both banks
// runs with full held high
module linear_probe_hash_map_core #(
  parameter int MAX_SLOTS_LOG = lphm_pkg::MAX_SLOTS_LOG_DEF,
  parameter int KEY_BITS      = lphm_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS    = lphm_pkg::VALUE_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // item input beats
  input  wire logic                push,
  output logic                     full,
  input  wire lphm_pkg::in_item_t  in_item_i,
  // result beats, oldest first
  output logic                     empty,
  input  wire logic                pop,
  output lphm_pkg::out_item_t      out_item_o,
  // capacity register write
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [3:0]          cfg_data_i
);
  import lphm_pkg::*;

  cmd_t        cmd;
  logic        cmd_valid, cmd_take;
  eng_status_t eng_status;
  logic        res_valid;

  // front: decode and a two deep command queue
  lphm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .in_item_i    (in_item_i),
    .eng_status_i (eng_status),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_take_i   (cmd_take)
  );

  // back: probe sequencer with the slot memory and the result register
  lphm_engine #(
    .MAX_SLOTS_LOG (MAX_SLOTS_LOG),
    .KEY_BITS      (KEY_BITS),
    .VALUE_BITS    (VALUE_BITS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_take_o   (cmd_take),
    .eng_status_o (eng_status),
    .res_valid_o  (res_valid),
    .res_o        (out_item_o),
    .res_take_i   (pop && res_valid)
  );

  // the user must write the register only while idle; the block does not enforce this, and the port is always open
  assign cfg_ready_o = 1'b1;
  assign empty       = !res_valid;

endmodule
`default_nettype wire
